// ===== rtl/core/qfnt_pkg.sv =====
// Shared types, widths and the helper function of the quad flat-normal triangulator.
package qfnt_pkg;

    // Coordinate width, the widths derived from it for the normal math, and others.
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int N_W        = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int S_W        = SQ_W + 2;
    localparam int ACC_W      = S_W + 14;
    localparam int Q_BITS     = 7;
    localparam int NORM_W     = Q_BITS + 1;
    localparam int COLOR_W    = 32;
    localparam int IDX_W      = 16;
    localparam int SLOT_W     = 3;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    // Square of the normal scale of 127.
    localparam logic [13:0] NORM_SCALE_SQ = 14'd16129;

    // Last slot of a run in each emission mode.
    localparam logic [SLOT_W-1:0] LAST_SLOT_TRI  = 3'd5;
    localparam logic [SLOT_W-1:0] LAST_SLOT_QUAD = 3'd3;

    // Register map.
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_QUAD_COLOR       = 3'd0;
    localparam reg_idx_t REG_NORMALS_ENABLED  = 3'd1;
    localparam reg_idx_t REG_USE_FIXED_NORMAL = 3'd2;
    localparam reg_idx_t REG_FIXED_NORMAL_X   = 3'd3;
    localparam reg_idx_t REG_FIXED_NORMAL_Y   = 3'd4;
    localparam reg_idx_t REG_FIXED_NORMAL_Z   = 3'd5;
    localparam reg_idx_t REG_TRIANGLE_MODE    = 3'd6;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef coord_t [2:0] vtx_t;
    typedef vtx_t [3:0] quad_t;
    typedef logic signed [NORM_W-1:0] norm_t;
    typedef norm_t [2:0] nvec_t;

    // Configuration seen by the vertex emitter.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               normals_en;
        logic               use_fixed;
        nvec_t              fixed;
        logic               tri_mode;
    } cfg_t;

    // Operands handed from the cross-product stages to the scaling search.
    typedef struct packed {
        quad_t                 quad;
        logic [2:0]            neg;
        logic                  zero;
        logic [S_W-1:0]        s;
        logic [2:0][ACC_W-1:0] r;
    } srch_t;

    // Source vertex of each slot in triangle mode: 0,1,2,0,2,3.
    function automatic logic [1:0] tri_vertex(input logic [SLOT_W-1:0] slot);
        logic [1:0] v;
        case (slot)
            3'd0:    v = 2'd0;
            3'd1:    v = 2'd1;
            3'd2:    v = 2'd2;
            3'd3:    v = 2'd0;
            3'd4:    v = 2'd2;
            3'd5:    v = 2'd3;
            default: v = 2'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/qfnt_if.sv =====
// Request channel interfaces for quads in and vertices out.
interface qfnt_in_if;
    logic                 valid;
    logic                 ready;
    qfnt_pkg::coord_t     v0_x;
    qfnt_pkg::coord_t     v0_y;
    qfnt_pkg::coord_t     v0_z;
    qfnt_pkg::coord_t     v1_x;
    qfnt_pkg::coord_t     v1_y;
    qfnt_pkg::coord_t     v1_z;
    qfnt_pkg::coord_t     v2_x;
    qfnt_pkg::coord_t     v2_y;
    qfnt_pkg::coord_t     v2_z;
    qfnt_pkg::coord_t     v3_x;
    qfnt_pkg::coord_t     v3_y;
    qfnt_pkg::coord_t     v3_z;

    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, input ready);
    modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, output ready);
endinterface

interface qfnt_out_if;
    logic                                valid;
    logic                                ready;
    qfnt_pkg::coord_t                    pos_x;
    qfnt_pkg::coord_t                    pos_y;
    qfnt_pkg::coord_t                    pos_z;
    logic [qfnt_pkg::COLOR_W-1:0]        vertex_color;
    qfnt_pkg::norm_t                     norm_x;
    qfnt_pkg::norm_t                     norm_y;
    qfnt_pkg::norm_t                     norm_z;
    logic [qfnt_pkg::SLOT_W-1:0]         slot;
    logic [qfnt_pkg::IDX_W-1:0]          quad_index;
    logic                                last_of_quad;

    modport source (output valid, pos_x, pos_y, pos_z, vertex_color, norm_x, norm_y,
                    norm_z, slot, quad_index, last_of_quad, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vertex_color, norm_x, norm_y,
                    norm_z, slot, quad_index, last_of_quad, output ready);
endinterface

// ===== rtl/core/qfnt_cross.sv =====
// Five-stage pipeline: edges, cross product, magnitudes, squares, length and targets.
module qfnt_cross (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  qfnt_pkg::quad_t     in_quad,
    output logic                out_valid,
    output qfnt_pkg::srch_t     out_data
);

    logic [4:0]             valid_reg;
    qfnt_pkg::quad_t        quad_reg [4];
    logic [2:0]             neg3_reg, neg4_reg;
    logic signed [qfnt_pkg::DIFF_W-1:0] u_reg [3];
    logic signed [qfnt_pkg::DIFF_W-1:0] w_reg [3];
    logic signed [qfnt_pkg::PROD_W-1:0] prod_reg [6];
    logic [qfnt_pkg::MAG_W-1:0] mag_reg [3];
    logic [qfnt_pkg::SQ_W-1:0]  sq_reg [3];
    qfnt_pkg::srch_t        out_reg;
    logic signed [qfnt_pkg::N_W-1:0] n_next [3];
    logic [qfnt_pkg::S_W-1:0] s_next;

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Cross product components from the stage-two products, and the squared length from the stage-four squares.
    always_comb
    begin
        n_next[0] = qfnt_pkg::N_W'(prod_reg[0]) - qfnt_pkg::N_W'(prod_reg[1]);
        n_next[1] = qfnt_pkg::N_W'(prod_reg[2]) - qfnt_pkg::N_W'(prod_reg[3]);
        n_next[2] = qfnt_pkg::N_W'(prod_reg[4]) - qfnt_pkg::N_W'(prod_reg[5]);
        s_next = qfnt_pkg::S_W'(sq_reg[0]) + qfnt_pkg::S_W'(sq_reg[1])
               + qfnt_pkg::S_W'(sq_reg[2]);
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage one: edge vectors v1-v0 and v2-v0.
            quad_reg[0] <= in_quad;
            for (int j = 0; j < 3; j++)
            begin
                u_reg[j] <= qfnt_pkg::DIFF_W'($signed(in_quad[1][j]))
                          - qfnt_pkg::DIFF_W'($signed(in_quad[0][j]));
                w_reg[j] <= qfnt_pkg::DIFF_W'($signed(in_quad[2][j]))
                          - qfnt_pkg::DIFF_W'($signed(in_quad[0][j]));
            end
            // Stage two: the six partial products.
            quad_reg[1] <= quad_reg[0];
            prod_reg[0] <= qfnt_pkg::PROD_W'(u_reg[1]) * qfnt_pkg::PROD_W'(w_reg[2]);
            prod_reg[1] <= qfnt_pkg::PROD_W'(u_reg[2]) * qfnt_pkg::PROD_W'(w_reg[1]);
            prod_reg[2] <= qfnt_pkg::PROD_W'(u_reg[2]) * qfnt_pkg::PROD_W'(w_reg[0]);
            prod_reg[3] <= qfnt_pkg::PROD_W'(u_reg[0]) * qfnt_pkg::PROD_W'(w_reg[2]);
            prod_reg[4] <= qfnt_pkg::PROD_W'(u_reg[0]) * qfnt_pkg::PROD_W'(w_reg[1]);
            prod_reg[5] <= qfnt_pkg::PROD_W'(u_reg[1]) * qfnt_pkg::PROD_W'(w_reg[0]);
            // Stage three: sign and magnitude of each component.
            quad_reg[2] <= quad_reg[1];
            for (int i = 0; i < 3; i++)
            begin
                neg3_reg[i] <= n_next[i][qfnt_pkg::N_W-1];
                mag_reg[i]  <= n_next[i][qfnt_pkg::N_W-1]
                             ? qfnt_pkg::MAG_W'(-n_next[i])
                             : qfnt_pkg::MAG_W'(n_next[i]);
            end
            // Stage four: squared magnitudes.
            quad_reg[3] <= quad_reg[2];
            neg4_reg    <= neg3_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= qfnt_pkg::SQ_W'(mag_reg[i]) * qfnt_pkg::SQ_W'(mag_reg[i]);
            end
            // Stage five: squared length and the scaled targets 16129*c*c.
            out_reg.quad <= quad_reg[3];
            out_reg.neg  <= neg4_reg;
            out_reg.s    <= s_next;
            out_reg.zero <= (s_next == '0);
            for (int i = 0; i < 3; i++)
            begin
                out_reg.r[i] <= qfnt_pkg::ACC_W'(sq_reg[i])
                              * qfnt_pkg::ACC_W'(qfnt_pkg::NORM_SCALE_SQ);
            end
        end
    end

    assign out_valid = valid_reg[4];
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/qfnt_search.sv =====
// Seven-stage bit search for the scaled normal, one result bit per stage.
module qfnt_search (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  qfnt_pkg::srch_t     in_data,
    output logic                out_valid,
    output qfnt_pkg::quad_t     out_quad,
    output qfnt_pkg::nvec_t     out_norm
);

    localparam int NS = qfnt_pkg::Q_BITS;

    logic                           valid_reg [NS];
    qfnt_pkg::srch_t                data_reg  [NS];
    logic [qfnt_pkg::ACC_W-1:0]     p_reg     [NS][3];
    logic [qfnt_pkg::ACC_W-1:0]     m_reg     [NS][3];
    logic [qfnt_pkg::Q_BITS-1:0]    q_reg     [NS][3];

    // Each stage tries to set one bit of q, keeping q*q*S and q*S up to date by adds.
    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int B = NS - 1 - k;

        logic                        src_valid;
        qfnt_pkg::srch_t             src_data;
        logic [qfnt_pkg::ACC_W-1:0]  src_p [3];
        logic [qfnt_pkg::ACC_W-1:0]  src_m [3];
        logic [qfnt_pkg::Q_BITS-1:0] src_q [3];
        logic [qfnt_pkg::ACC_W-1:0]  cand  [3];
        logic [qfnt_pkg::ACC_W-1:0]  s_ext;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                src_valid = in_valid;
                src_data  = in_data;
                for (int i = 0; i < 3; i++)
                begin
                    src_p[i] = '0;
                    src_m[i] = '0;
                    src_q[i] = '0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                src_valid = valid_reg[k-1];
                src_data  = data_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    src_p[i] = p_reg[k-1][i];
                    src_m[i] = m_reg[k-1][i];
                    src_q[i] = q_reg[k-1][i];
                end
            end
        end

        // Trial value (q + 2^B)^2 * S.
        always_comb
        begin
            s_ext = qfnt_pkg::ACC_W'(src_data.s);
            for (int i = 0; i < 3; i++)
            begin
                cand[i] = src_p[i] + (src_m[i] << (B + 1)) + (s_ext << (2 * B));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                data_reg[k] <= src_data;
                for (int i = 0; i < 3; i++)
                begin
                    if (cand[i] <= src_data.r[i])
                    begin
                        p_reg[k][i] <= cand[i];
                        m_reg[k][i] <= src_m[i] + (s_ext << B);
                        q_reg[k][i] <= src_q[i] | (qfnt_pkg::Q_BITS'(1) << B);
                    end
                    else
                    begin
                        p_reg[k][i] <= src_p[i];
                        m_reg[k][i] <= src_m[i];
                        q_reg[k][i] <= src_q[i];
                    end
                end
            end
        end
    end

    // Apply sign; a zero-length cross product gives a zero normal.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (data_reg[NS-1].zero)
            begin
                out_norm[i] = '0;
            end
            else if (data_reg[NS-1].neg[i])
            begin
                out_norm[i] = -qfnt_pkg::NORM_W'(q_reg[NS-1][i]);
            end
            else
            begin
                out_norm[i] = qfnt_pkg::NORM_W'(q_reg[NS-1][i]);
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_quad  = data_reg[NS-1].quad;

endmodule

// ===== rtl/core/qfnt_emit.sv =====
// Vertex emitter: holds one quad and sends its four or six vertices.
module qfnt_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  qfnt_pkg::quad_t     in_quad,
    input  qfnt_pkg::nvec_t     in_norm,
    input  qfnt_pkg::cfg_t      cfg,
    output logic                take,
    qfnt_out_if.source          vo
);

    logic                              busy_reg;
    logic                              tri_reg;
    logic [qfnt_pkg::SLOT_W-1:0]       slot_reg;
    logic [qfnt_pkg::IDX_W-1:0]        cnt_reg;
    logic [qfnt_pkg::IDX_W-1:0]        idx_reg;
    qfnt_pkg::quad_t                   quad_reg;
    qfnt_pkg::nvec_t                   norm_reg;
    logic                              last;
    logic [1:0]                        vsel;

    assign last = (slot_reg == (tri_reg ? qfnt_pkg::LAST_SLOT_TRI : qfnt_pkg::LAST_SLOT_QUAD));
    assign take = in_valid && (!busy_reg || (vo.ready && last));

    // Run control and quad counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            tri_reg  <= 1'b1;
            slot_reg <= '0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= 1'b1;
            tri_reg  <= cfg.tri_mode;
            slot_reg <= '0;
            idx_reg  <= cnt_reg;
            cnt_reg  <= cnt_reg + qfnt_pkg::IDX_W'(1);
        end
        else if (busy_reg && vo.ready)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                slot_reg <= slot_reg + qfnt_pkg::SLOT_W'(1);
            end
        end
    end

    // Quad payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            quad_reg <= in_quad;
            norm_reg <= in_norm;
        end
    end

    // Pick the source vertex of the current slot.
    assign vsel = tri_reg ? qfnt_pkg::tri_vertex(slot_reg) : slot_reg[1:0];

    assign vo.valid        = busy_reg;
    assign vo.pos_x        = quad_reg[vsel][0];
    assign vo.pos_y        = quad_reg[vsel][1];
    assign vo.pos_z        = quad_reg[vsel][2];
    assign vo.vertex_color = cfg.color;
    assign vo.norm_x       = norm_reg[0];
    assign vo.norm_y       = norm_reg[1];
    assign vo.norm_z       = norm_reg[2];
    assign vo.slot         = slot_reg;
    assign vo.quad_index   = idx_reg;
    assign vo.last_of_quad = last;

endmodule

// ===== rtl/core/quad_flat_normal_triangulator_unit.sv =====
// Top level: register port, normal pipeline and vertex emitter.
//
// Takes one quad of four signed vertices per request and sends it as six triangle
// vertices (order 0,1,2,0,2,3) or four quad vertices, each with the configured color,
// one normal for the whole quad, its slot, the quad index and a last-of-quad flag.
// The flat normal passes a 12-stage pipeline (five stages of cross product, length
// and targets, then seven stages that settle one bit of the scaled magnitude each),
// and the emitter adds one more register before a quad's first vertex is valid on
// the output. The vertex emitter drives one vertex per cycle while the output is
// ready, from a single output port, so each quad holds the port for its six vertices
// in triangle mode or its four in quad mode; the pipeline keeps accepting quads until
// its last stage holds a quad that the emitter cannot take yet, and then the whole
// pipeline and the input stall. The user must write registers over the APB port only
// while no quad is in flight; the block itself does not enforce this.
module quad_flat_normal_triangulator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qfnt_pkg::ADDR_W-1:0]   paddr,
    input  logic [qfnt_pkg::DATA_W-1:0]   pwdata,
    output logic [qfnt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    qfnt_in_if.sink                       quad_in,
    qfnt_out_if.source                    vtx_out
);

    qfnt_pkg::cfg_t     cfg_reg;
    qfnt_pkg::reg_idx_t reg_idx;
    qfnt_pkg::quad_t    in_quad;
    logic               adv;
    logic               take;
    logic               srch_valid_in;
    qfnt_pkg::srch_t    srch_data_in;
    logic               fin_valid;
    qfnt_pkg::quad_t    fin_quad;
    qfnt_pkg::nvec_t    fin_norm;
    qfnt_pkg::nvec_t    sel_norm;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{color: '0, normals_en: 1'b0, use_fixed: 1'b0, fixed: '0,
                         tri_mode: 1'b1};
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                qfnt_pkg::REG_QUAD_COLOR:       cfg_reg.color      <= pwdata;
                qfnt_pkg::REG_NORMALS_ENABLED:  cfg_reg.normals_en <= pwdata[0];
                qfnt_pkg::REG_USE_FIXED_NORMAL: cfg_reg.use_fixed  <= pwdata[0];
                qfnt_pkg::REG_FIXED_NORMAL_X:   cfg_reg.fixed[0]   <= pwdata[7:0];
                qfnt_pkg::REG_FIXED_NORMAL_Y:   cfg_reg.fixed[1]   <= pwdata[7:0];
                qfnt_pkg::REG_FIXED_NORMAL_Z:   cfg_reg.fixed[2]   <= pwdata[7:0];
                qfnt_pkg::REG_TRIANGLE_MODE:    cfg_reg.tri_mode   <= pwdata[0];
                default:                        ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (reg_idx)
            qfnt_pkg::REG_QUAD_COLOR:       prdata = cfg_reg.color;
            qfnt_pkg::REG_NORMALS_ENABLED:  prdata = qfnt_pkg::DATA_W'(cfg_reg.normals_en);
            qfnt_pkg::REG_USE_FIXED_NORMAL: prdata = qfnt_pkg::DATA_W'(cfg_reg.use_fixed);
            qfnt_pkg::REG_FIXED_NORMAL_X:   prdata = qfnt_pkg::DATA_W'(cfg_reg.fixed[0]);
            qfnt_pkg::REG_FIXED_NORMAL_Y:   prdata = qfnt_pkg::DATA_W'(cfg_reg.fixed[1]);
            qfnt_pkg::REG_FIXED_NORMAL_Z:   prdata = qfnt_pkg::DATA_W'(cfg_reg.fixed[2]);
            qfnt_pkg::REG_TRIANGLE_MODE:    prdata = qfnt_pkg::DATA_W'(cfg_reg.tri_mode);
            default:                        prdata = '0;
        endcase
    end

    // Gather the request fields.
    always_comb
    begin
        in_quad[0][0] = quad_in.v0_x;
        in_quad[0][1] = quad_in.v0_y;
        in_quad[0][2] = quad_in.v0_z;
        in_quad[1][0] = quad_in.v1_x;
        in_quad[1][1] = quad_in.v1_y;
        in_quad[1][2] = quad_in.v1_z;
        in_quad[2][0] = quad_in.v2_x;
        in_quad[2][1] = quad_in.v2_y;
        in_quad[2][2] = quad_in.v2_z;
        in_quad[3][0] = quad_in.v3_x;
        in_quad[3][1] = quad_in.v3_y;
        in_quad[3][2] = quad_in.v3_z;
    end

    // The whole pipeline moves unless its last stage holds a quad the emitter cannot take.
    assign adv           = !fin_valid || take;
    assign quad_in.ready = adv;

    qfnt_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (quad_in.valid),
        .in_quad   (in_quad),
        .out_valid (srch_valid_in),
        .out_data  (srch_data_in)
    );

    qfnt_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (srch_valid_in),
        .in_data   (srch_data_in),
        .out_valid (fin_valid),
        .out_quad  (fin_quad),
        .out_norm  (fin_norm)
    );

    // Normal source: off, fixed or computed.
    always_comb
    begin
        if (!cfg_reg.normals_en)
        begin
            sel_norm = '0;
        end
        else if (cfg_reg.use_fixed)
        begin
            sel_norm = cfg_reg.fixed;
        end
        else
        begin
            sel_norm = fin_norm;
        end
    end

    qfnt_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fin_valid),
        .in_quad  (fin_quad),
        .in_norm  (sel_norm),
        .cfg      (cfg_reg),
        .take     (take),
        .vo       (vtx_out)
    );

endmodule
